>>> design/scm_pkg.sv
package scm_pkg;

	// Pixel and configuration port widths
	localparam int PIX_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 13;
	localparam int THR_W      = 3;

	typedef logic [PIX_W-1:0] pixel_t;

	// Item opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH = 2'd3;

	// Register reset values
	localparam logic [IMG_W_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;
	localparam pixel_t             COLOR_RST  = 24'hffffff;
	localparam logic [THR_W-1:0]   THRESH_RST = 3'd2;

	// Frame-edge flags of the pixel being emitted
	typedef struct packed {
		logic has_left;
		logic has_right;
		logic has_up;
		logic has_down;
		logic last;
	} edge_info_t;

endpackage

>>> design/scm_ram.sv
module scm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rd_q;

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

>>> design/scm_delay_line.sv
module scm_delay_line #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  logic [$clog2(DEPTH+1)-1:0] len,
	input  logic                       shift,
	input  logic [WIDTH-1:0]           din,
	output logic [WIDTH-1:0]           dout
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH+1);

	logic [AW-1:0]    ptr_q;
	logic [AW-1:0]    ptr_nxt;
	logic [AW-1:0]    rd_addr;
	logic [WIDTH-1:0] rd_data;
	logic             byp_q;
	logic [WIDTH-1:0] byp_data_q;

	// Circular pointer over len entries; dout is always the oldest entry
	always_comb begin
		if (LW'(ptr_q) >= len - LW'(1)) begin
			ptr_nxt = '0;
		end else begin
			ptr_nxt = ptr_q + AW'(1);
		end
		rd_addr = shift ? ptr_nxt : ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			byp_q <= 1'b0;
		end else if (clear) begin
			ptr_q <= '0;
			byp_q <= 1'b0;
		end else begin
			if (shift) begin
				ptr_q <= ptr_nxt;
			end
			// length one: new oldest entry is the one being written
			byp_q <= shift && (ptr_nxt == ptr_q);
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byp_data_q <= din;
		end
	end

	scm_ram #(
		.WIDTH (WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (shift),
		.waddr (ptr_q),
		.wdata (din),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign dout = byp_q ? byp_data_q : rd_data;

endmodule

>>> design/segment_contour_marker_unit.sv
// Segment contour marker.
// Pixels of a segmented frame enter in raster order on the in channel
// (valid/ready, opcode = pixel). Each pixel leaves on the out channel, either
// unchanged or replaced by contour_color when more than diff_threshold of its
// in-frame, unmarked neighbors carry a different color. A pixel leaves once
// the pixel width+1 places after it has arrived; after the last pixel of a
// frame, drain items (opcode = drain) push out the remaining width+1 pixels.
// last_of_frame marks the final pixel, after which the next pixel opens a new
// frame.
// Throughput is one item per clock while no padding shift runs and out does not
// stall. A result passes through the 3x3 window register and then the output
// register before it appears on out. Frames of a single row take one extra
// window shift after their last pixel, with in_ready low.
// The configuration port is always ready; a write of image_width or
// image_height restarts the frame. Reset loads the default registers and
// starts an empty frame. If out_ready is low, one result waits in the output
// register and one in the window stage; after that in_ready drops.
module segment_contour_marker_unit #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [scm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             opcode,
	input  logic [scm_pkg::PIX_W-1:0]        pixel_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [scm_pkg::PIX_W-1:0]        out_pixel,
	output logic                             last_of_frame
);

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int PW  = $clog2(MAX_WIDTH + 2);
	localparam int EWW = (WW > scm_pkg::IMG_W_W) ? WW : scm_pkg::IMG_W_W;
	localparam int EHW = (HW > scm_pkg::IMG_H_W) ? HW : scm_pkg::IMG_H_W;
	localparam int PX  = scm_pkg::PIX_W;

	// Configuration registers
	logic [scm_pkg::IMG_W_W-1:0] width_q;
	logic [scm_pkg::IMG_H_W-1:0] height_q;
	scm_pkg::pixel_t             color_q;
	logic [scm_pkg::THR_W-1:0]   thresh_q;
	logic                        size_wr;

	// Frame counters
	logic [CW-1:0] in_col_q;
	logic [HW-1:0] in_row_q;
	logic [CW-1:0] out_col_q;
	logic [HW-1:0] out_row_q;
	logic [PW-1:0] pending_q;
	logic [1:0]    pad_q;

	// Clamped frame size
	logic [EWW-1:0] w_ext;
	logic [EHW-1:0] h_ext;
	logic [WW-1:0]  w;
	logic [HW-1:0]  h;
	logic [WW-1:0]  w_m1;
	logic [HW-1:0]  h_m1;
	logic           w_one;
	logic [WW-1:0]  mark_len;
	logic           small_frame;

	// Handshake and control
	logic                s1_adv;
	logic                acc;
	logic                pad_busy;
	logic                in_done;
	logic                frame_pix;
	logic                drain_emit;
	logic                pix_emit;
	logic                emit;
	logic                win_shift;
	logic                in_last_pix;
	scm_pkg::edge_info_t info;
	scm_pkg::pixel_t     shift_pix;

	// Window stage
	logic                valid_s1;
	scm_pkg::edge_info_t info_s1;
	scm_pkg::pixel_t     win_q [0:2][0:2];
	logic [2*PX-1:0]     lb_din;
	logic [2*PX-1:0]     lb_dout;
	scm_pkg::pixel_t     lb_pw;
	scm_pkg::pixel_t     lb_p2w;

	// Marks of already emitted neighbors
	logic mk_l_q;
	logic mk_u_q;
	logic mk_ul_q;
	logic mk_ur;
	logic mark_up;

	// Neighbor count
	scm_pkg::pixel_t own;
	logic [7:0]      diff;
	logic [3:0]      np;
	logic            paint;

	// Output register
	logic            out_valid_q;
	scm_pkg::pixel_t out_pixel_q;
	logic            out_last_q;

	assign cfg_ready = 1'b1;
	assign size_wr   = cfg_valid && (cfg_index == scm_pkg::REG_WIDTH ||
		cfg_index == scm_pkg::REG_HEIGHT);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= scm_pkg::WIDTH_RST;
			height_q <= scm_pkg::HEIGHT_RST;
			color_q  <= scm_pkg::COLOR_RST;
			thresh_q <= scm_pkg::THRESH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scm_pkg::REG_WIDTH:  width_q  <= cfg_data[scm_pkg::IMG_W_W-1:0];
				scm_pkg::REG_HEIGHT: height_q <= cfg_data[scm_pkg::IMG_H_W-1:0];
				scm_pkg::REG_COLOR:  color_q  <= cfg_data[PX-1:0];
				scm_pkg::REG_THRESH: thresh_q <= cfg_data[scm_pkg::THR_W-1:0];
			endcase
		end
	end

	// Clamp size to 1..MAX
	always_comb begin
		w_ext = EWW'(width_q);
		h_ext = EHW'(height_q);
		if (w_ext == '0) begin
			w_ext = EWW'(1);
		end else if (w_ext > EWW'(MAX_WIDTH)) begin
			w_ext = EWW'(MAX_WIDTH);
		end
		if (h_ext == '0) begin
			h_ext = EHW'(1);
		end else if (h_ext > EHW'(MAX_HEIGHT)) begin
			h_ext = EHW'(MAX_HEIGHT);
		end
		w           = WW'(w_ext);
		h           = HW'(h_ext);
		w_m1        = w - WW'(1);
		h_m1        = h - HW'(1);
		w_one       = (w == WW'(1));
		mark_len    = w_one ? WW'(1) : w_m1;
		small_frame = (h == HW'(1));
	end

	// Item decode
	always_comb begin
		pad_busy    = (pad_q != 2'd0);
		s1_adv      = valid_s1 && (!out_valid_q || out_ready);
		in_ready    = !pad_busy && (!valid_s1 || s1_adv);
		acc         = in_valid && in_ready;
		in_done     = (in_row_q == h);
		frame_pix   = acc && (opcode == scm_pkg::OP_PIXEL) && !in_done;
		drain_emit  = acc && !frame_pix && in_done && (pending_q != '0);
		pix_emit    = frame_pix && (pending_q > PW'(w));
		emit        = pix_emit || drain_emit;
		win_shift   = frame_pix || drain_emit || pad_busy;
		in_last_pix = (in_row_q == h_m1) && (WW'(in_col_q) == w_m1);
		shift_pix   = frame_pix ? pixel_value : '0;

		info.has_left  = (out_col_q != '0);
		info.has_right = (WW'(out_col_q) != w_m1);
		info.has_up    = (out_row_q != '0);
		info.has_down  = (out_row_q != h_m1);
		info.last      = (out_row_q == h_m1) && (WW'(out_col_q) == w_m1);
	end

	// Raster counters, pending count, single-row padding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			pad_q     <= 2'd0;
		end else if (size_wr) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
			pad_q     <= 2'd0;
		end else begin
			if (pad_busy) begin
				pad_q <= pad_q - 2'd1;
			end
			if (frame_pix) begin
				if (WW'(in_col_q) == w_m1) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + HW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				// window must reach width+1 shifts past pixel 0
				if (in_last_pix && small_frame) begin
					pad_q <= 2'd1;
				end
				if (!pix_emit) begin
					pending_q <= pending_q + PW'(1);
				end
			end else if (drain_emit) begin
				pending_q <= pending_q - PW'(1);
			end
			if (emit) begin
				if (info.last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					pending_q <= '0;
				end else if (WW'(out_col_q) == w_m1) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + HW'(1);
				end else begin
					out_col_q <= out_col_q + CW'(1);
				end
			end
		end
	end

	// Two row delays share one memory: entry holds {p, p-w}
	assign lb_din = {shift_pix, lb_pw};
	assign lb_pw  = lb_dout[2*PX-1:PX];
	assign lb_p2w = lb_dout[PX-1:0];

	scm_delay_line #(
		.WIDTH (2 * PX),
		.DEPTH (MAX_WIDTH)
	) u_row_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (size_wr),
		.len    (w),
		.shift  (win_shift),
		.din    (lb_din),
		.dout   (lb_dout)
	);

	// Marks delayed by width-1 emissions: oldest is the upper-right mark
	scm_delay_line #(
		.WIDTH (1),
		.DEPTH (MAX_WIDTH)
	) u_mark_delay (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (size_wr),
		.len    (mark_len),
		.shift  (s1_adv),
		.din    (paint),
		.dout   (mk_ur)
	);

	// Window stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= emit;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// 3x3 window; row 0 is newest, column 0 is newest
	always_ff @(posedge clk) begin
		if (acc && emit) begin
			info_s1 <= info;
		end
		if (win_shift) begin
			win_q[0][0] <= shift_pix;
			win_q[1][0] <= lb_pw;
			win_q[2][0] <= lb_p2w;
			for (int j = 0; j < 3; j++) begin
				for (int k = 1; k < 3; k++) begin
					win_q[j][k] <= win_q[j][k-1];
				end
			end
		end
		if (s1_adv) begin
			mk_l_q  <= paint;
			mk_u_q  <= mk_ur;
			mk_ul_q <= mk_u_q;
		end
	end

	// Count differing, unmarked in-frame neighbors of the center pixel
	always_comb begin
		own     = win_q[1][1];
		mark_up = w_one ? mk_l_q : mk_u_q;
		diff[0] = info_s1.has_left && !mk_l_q && (win_q[1][2] != own);
		diff[1] = info_s1.has_up && info_s1.has_left && !mk_ul_q && (win_q[2][2] != own);
		diff[2] = info_s1.has_up && !mark_up && (win_q[2][1] != own);
		diff[3] = info_s1.has_up && info_s1.has_right && !mk_ur && (win_q[2][0] != own);
		diff[4] = info_s1.has_right && (win_q[1][0] != own);
		diff[5] = info_s1.has_down && info_s1.has_right && (win_q[0][0] != own);
		diff[6] = info_s1.has_down && (win_q[0][1] != own);
		diff[7] = info_s1.has_down && info_s1.has_left && (win_q[0][2] != own);
		np = '0;
		for (int i = 0; i < 8; i++) begin
			np = np + {3'b000, diff[i]};
		end
		paint = (np > {1'b0, thresh_q});
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_pixel_q <= paint ? color_q : own;
			out_last_q  <= info_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_pixel     = out_pixel_q;
	assign last_of_frame = out_last_q;

	// Padding shifts run alone, after the whole frame is in, with no result queued
	a_pad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		pad_q != 2'd0 |-> !in_ready && (in_row_q == h) && !valid_s1)
		else $error("padding shift overlaps item traffic");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(WW'(in_col_q) < w) && (WW'(out_col_q) < w))
		else $error("column counter beyond frame width");

	a_done_col: assert property (@(posedge clk) disable iff (!arst_n)
		(in_row_q == h) |-> (in_col_q == '0))
		else $error("input complete with nonzero column");

	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= PW'(w) + PW'(1))
		else $error("pending pixels exceed width+1");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		drain_emit |-> (in_row_q == h) && (pad_q == 2'd0))
		else $error("drain emitted before frame fully received");

endmodule
